[sv/bdeque_pkg.sv]
package bdeque_pkg;

  // Capacity of the circular store and the widths that follow from it.
  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Request kinds.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_TRAVERSE   = 3'd4;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Operations on the store and its pointers.
  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_PUSH_FRONT,
    MOP_PUSH_BACK,
    MOP_POP_FRONT,
    MOP_POP_BACK,
    MOP_TRAV_FIRST,
    MOP_TRAV_NEXT
  } mem_op_e;

  // What the output register is loaded with.
  typedef enum logic [2:0] {
    RES_PUSH,
    RES_FULL,
    RES_EMPTY,
    RES_POP,
    RES_TRAV,
    RES_TERM
  } res_src_e;

  typedef struct packed {
    mem_op_e  mop;
    logic     load;
    res_src_e src;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic trav_done;
    logic out_free;
  } stat_t;

endpackage

[sv/bdeque_ctrl.sv]
module bdeque_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  bdeque_pkg::stat_t   stat_i,
  output bdeque_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_POP  = 4'b0010,
    ST_TRAV = 4'b0100,
    ST_TERM = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == ST_IDLE) && stat_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.mop  = bdeque_pkg::MOP_NONE;
    cmd_o.load = 1'b0;
    cmd_o.src  = bdeque_pkg::RES_TERM;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_i)
            bdeque_pkg::KIND_PUSH_FRONT, bdeque_pkg::KIND_PUSH_BACK: begin
              cmd_o.load = 1'b1;
              if (stat_i.full) begin
                cmd_o.src = bdeque_pkg::RES_FULL;
              end else begin
                cmd_o.src = bdeque_pkg::RES_PUSH;
                cmd_o.mop = (kind_i == bdeque_pkg::KIND_PUSH_FRONT) ?
                            bdeque_pkg::MOP_PUSH_FRONT : bdeque_pkg::MOP_PUSH_BACK;
              end
            end
            bdeque_pkg::KIND_POP_FRONT, bdeque_pkg::KIND_POP_BACK: begin
              if (stat_i.empty) begin
                cmd_o.load = 1'b1;
                cmd_o.src  = bdeque_pkg::RES_EMPTY;
              end else begin
                cmd_o.mop = (kind_i == bdeque_pkg::KIND_POP_FRONT) ?
                            bdeque_pkg::MOP_POP_FRONT : bdeque_pkg::MOP_POP_BACK;
                state_d   = ST_POP;
              end
            end
            bdeque_pkg::KIND_TRAVERSE: begin
              if (stat_i.empty) begin
                cmd_o.load = 1'b1;
                cmd_o.src  = bdeque_pkg::RES_TERM;
              end else begin
                cmd_o.mop = bdeque_pkg::MOP_TRAV_FIRST;
                state_d   = ST_TRAV;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_POP: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.src  = bdeque_pkg::RES_POP;
          state_d    = ST_IDLE;
        end
      end
      ST_TRAV: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.src  = bdeque_pkg::RES_TRAV;
          if (stat_i.trav_done) begin
            state_d = ST_TERM;
          end else begin
            cmd_o.mop = bdeque_pkg::MOP_TRAV_NEXT;
          end
        end
      end
      ST_TERM: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.src  = bdeque_pkg::RES_TERM;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/bdeque_dp.sv]
module bdeque_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic signed [bdeque_pkg::DATA_W-1:0]    value_i,
  input  bdeque_pkg::cmd_t                        cmd_i,
  output bdeque_pkg::stat_t                       stat_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [1:0]                              status_o,
  output logic signed [bdeque_pkg::DATA_W-1:0]    value_res_o,
  output logic                                    is_element_o,
  output logic                                    last_o
);

  localparam int IW = bdeque_pkg::IDX_W;
  localparam int CW = bdeque_pkg::CNT_W;
  localparam int SW = bdeque_pkg::CNT_W + 1;
  localparam int DW = bdeque_pkg::DATA_W;

  logic [DW-1:0] mem [bdeque_pkg::DEPTH];
  logic [DW-1:0] rd_q;
  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] trav_q, trav_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q;
  logic [DW-1:0] value_q;
  logic          elem_q, last_q;

  logic          we, re;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [IW-1:0] front_dec, front_inc;

  // Position of the element that lies off places behind the front, modulo DEPTH.
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(bdeque_pkg::DEPTH)) begin
      sum = sum - SW'(bdeque_pkg::DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign front_dec = (front_q == '0) ? IW'(bdeque_pkg::DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == IW'(bdeque_pkg::DEPTH - 1)) ? '0 : front_q + 1'b1;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    trav_d  = trav_q;
    we      = 1'b0;
    re      = 1'b0;
    wr_addr = front_q;
    rd_addr = front_q;
    case (cmd_i.mop)
      bdeque_pkg::MOP_PUSH_FRONT: begin
        we      = 1'b1;
        wr_addr = front_dec;
        front_d = front_dec;
        count_d = count_q + 1'b1;
      end
      bdeque_pkg::MOP_PUSH_BACK: begin
        we      = 1'b1;
        wr_addr = slot(front_q, count_q);
        count_d = count_q + 1'b1;
      end
      bdeque_pkg::MOP_POP_FRONT: begin
        re      = 1'b1;
        rd_addr = front_q;
        front_d = front_inc;
        count_d = count_q - 1'b1;
      end
      bdeque_pkg::MOP_POP_BACK: begin
        re      = 1'b1;
        rd_addr = slot(front_q, count_q - 1'b1);
        count_d = count_q - 1'b1;
      end
      bdeque_pkg::MOP_TRAV_FIRST: begin
        re      = 1'b1;
        rd_addr = front_q;
        trav_d  = CW'(1);
      end
      bdeque_pkg::MOP_TRAV_NEXT: begin
        re      = 1'b1;
        rd_addr = slot(front_q, trav_q);
        trav_d  = trav_q + 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= value_i;
    end
    if (re) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      trav_q  <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      trav_q  <= trav_d;
    end
  end

  // Output register.
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.full      = (count_q == CW'(bdeque_pkg::DEPTH));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.trav_done = (trav_q == count_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (cmd_i.src)
        bdeque_pkg::RES_PUSH: begin
          status_q <= bdeque_pkg::STAT_OK;
          value_q  <= value_i;
          elem_q   <= 1'b1;
          last_q   <= 1'b1;
        end
        bdeque_pkg::RES_FULL: begin
          status_q <= bdeque_pkg::STAT_FULL;
          value_q  <= '0;
          elem_q   <= 1'b0;
          last_q   <= 1'b1;
        end
        bdeque_pkg::RES_EMPTY: begin
          status_q <= bdeque_pkg::STAT_EMPTY;
          value_q  <= '0;
          elem_q   <= 1'b0;
          last_q   <= 1'b1;
        end
        bdeque_pkg::RES_POP: begin
          status_q <= bdeque_pkg::STAT_OK;
          value_q  <= rd_q;
          elem_q   <= 1'b1;
          last_q   <= 1'b1;
        end
        bdeque_pkg::RES_TRAV: begin
          status_q <= bdeque_pkg::STAT_OK;
          value_q  <= rd_q;
          elem_q   <= 1'b1;
          last_q   <= 1'b0;
        end
        default: begin
          status_q <= bdeque_pkg::STAT_OK;
          value_q  <= '0;
          elem_q   <= 1'b0;
          last_q   <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign value_res_o  = value_q;
  assign is_element_o = elem_q;
  assign last_o       = last_q;

endmodule

[sv/bounded_deque_with_traversal_top.sv]
// A push, a rejected request or an empty traverse answers in the cycle after
// it is taken; a pop reads via the store's single read port into a read
// register, then loads the output register. One push per cycle while the
// output is not stalled; a pop holds the block until its result is loaded;
// a traverse of N > 0 values holds it to its end result, one read per value.
// Reset clears the pointers, count, output valid and controller, not the store.

module bounded_deque_with_traversal_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [2:0]                            kind_i,
  input  logic signed [bdeque_pkg::DATA_W-1:0]  value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            status_o,
  output logic signed [bdeque_pkg::DATA_W-1:0]  value_res_o,
  output logic                                  is_element_o,
  output logic                                  last_o
);

  // The controller decodes each request and sequences the store accesses;
  // the datapath holds the circular store, the front pointer, the element
  // count, the traversal offset and the output register.
  bdeque_pkg::cmd_t  cmd;
  bdeque_pkg::stat_t stat;

  bdeque_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bdeque_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .value_res_o  (value_res_o),
    .is_element_o (is_element_o),
    .last_o       (last_o)
  );

  // The output register is loaded only when its previous result is gone.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> stat.out_free)
    else $error("result loaded over one not yet taken");

  // A push reaches the store only when there is room in it.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mop == bdeque_pkg::MOP_PUSH_FRONT || cmd.mop == bdeque_pkg::MOP_PUSH_BACK)
    |-> !stat.full)
    else $error("push issued on a full store");

  // A pop or the first read of a traversal happens only when something is stored.
  a_pop_some: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.mop == bdeque_pkg::MOP_POP_FRONT || cmd.mop == bdeque_pkg::MOP_POP_BACK ||
     cmd.mop == bdeque_pkg::MOP_TRAV_FIRST) |-> !stat.empty)
    else $error("read issued on an empty store");

  // A result that carries a stored value always reports success.
  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_element_o) |-> (status_o == bdeque_pkg::STAT_OK))
    else $error("element result with a failure status");

endmodule
